FILE: rtl/core/dte_pkg.sv
`default_nettype none
package dte_pkg;

   // Default sizes of the tree, the covariate store and the action set.
   localparam int DEFAULT_MAX_DEPTH      = 4;
   localparam int DEFAULT_NUM_COVARIATES = 16;
   localparam int DEFAULT_NUM_ACTIONS    = 16;

   // Widths of the item fields.
   localparam int OPCODE_W      = 3;
   localparam int NODE_IDX_W    = 5;
   localparam int COV_IDX_W     = 4;
   localparam int VALUE_W       = 32;
   localparam int LEAF_ACTION_W = 4;
   localparam int REWARD_W      = 32;
   localparam int ACTION_W      = 5;
   localparam int ACC_W         = 48;
   localparam int STATUS_W      = 2;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_WRITE_SPLIT   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE_LEAF    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_LOAD_COV      = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_CLASSIFY      = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_ADD_REWARD    = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_READ_REWARD   = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PAST_LAST = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

   // Action code of a node that has none assigned.
   localparam logic [ACTION_W-1:0] ACTION_NONE = {ACTION_W{1'b1}};

   // Bounds of the reward accumulator.
   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Split information of one node as held in the node table.
   typedef struct packed {
      logic                          split;
      logic [COV_IDX_W-1:0]          covariate;
      logic [VALUE_W-1:0]            threshold;
   } node_info_type;

   localparam int NODE_INFO_W = $bits(node_info_type);

endpackage
`default_nettype wire

FILE: rtl/core/decision_tree_evaluator_core.sv
`default_nettype none
// Channel    Ports                                   Handshake
// ---------  --------------------------------------  ---------------------------------
// request    req_opcode .. req_reward                accepted when start and not busy
// response   rsp_action_out, rsp_reward_out,         rsp_valid high for one cycle,
//            rsp_status                              taken at the end of that cycle
//
// Writes and covariate loads are done when accepted; the item's result shows in the next cycle.
// A reward read returns through S_READ. Classify and reward-add walks pass through S_NODE
// (node table read) and S_FEAT (covariate store read and compare) for each split
// passed, and through S_NODE once more at the node where the walk stops, where the
// result is registered.
// After reset a clearing pass over every node and covariate address runs
// with busy high. The receiver cannot stall, so results never wait.
module decision_tree_evaluator_core #(
   parameter int MAX_DEPTH      = dte_pkg::DEFAULT_MAX_DEPTH,
   parameter int NUM_COVARIATES = dte_pkg::DEFAULT_NUM_COVARIATES,
   parameter int NUM_ACTIONS    = dte_pkg::DEFAULT_NUM_ACTIONS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [dte_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire logic [dte_pkg::NODE_IDX_W-1:0]    req_node_index,
   input  wire logic [dte_pkg::COV_IDX_W-1:0]     req_covariate_index,
   input  wire logic signed [dte_pkg::VALUE_W-1:0] req_value,
   input  wire logic [dte_pkg::LEAF_ACTION_W-1:0] req_leaf_action,
   input  wire logic signed [dte_pkg::REWARD_W-1:0] req_reward,
   output logic                                   rsp_valid,
   output logic signed [dte_pkg::ACTION_W-1:0]    rsp_action_out,
   output logic signed [dte_pkg::ACC_W-1:0]       rsp_reward_out,
   output logic [dte_pkg::STATUS_W-1:0]           rsp_status
);

   import dte_pkg::*;

   localparam int NUM_NODES  = (1 << (MAX_DEPTH + 1)) - 1;
   localparam int FIRST_LEAF = (NUM_NODES - 1) / 2;
   localparam int NODE_AW    = $clog2(NUM_NODES);
   localparam int FEAT_AW    = $clog2(NUM_COVARIATES);
   localparam int CLEAR_LEN  = (NUM_NODES > NUM_COVARIATES) ? NUM_NODES : NUM_COVARIATES;
   localparam int CLR_W      = $clog2(CLEAR_LEN);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_NODE  = 5'b00100,
      S_FEAT  = 5'b01000,
      S_READ  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [CLR_W-1:0]     clear_ff, clear_in;
   logic [NODE_AW-1:0]   node_ff, node_in;
   logic [VALUE_W-1:0]   thr_ff, thr_in;
   logic [REWARD_W-1:0]  amount_ff, amount_in;
   logic                 add_ff, add_in;
   logic                 sat_ff, sat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ACTION_W-1:0]  rsp_action_ff, rsp_action_in;
   logic [ACC_W-1:0]     rsp_reward_ff, rsp_reward_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic                 info_we, action_we, reward_we, feat_we;
   logic [NODE_AW-1:0]   node_waddr, node_raddr;
   logic [NODE_INFO_W-1:0] info_wdata, info_rdata;
   logic [ACTION_W-1:0]  action_wdata, action_rdata;
   logic [ACC_W-1:0]     reward_wdata, reward_rdata;
   logic [FEAT_AW-1:0]   feat_waddr, feat_raddr;
   logic [VALUE_W-1:0]   feat_wdata, feat_rdata;

   node_info_type        info_rd, info_wr;
   logic                 accept;
   logic                 node_ok, cov_ok, act_ok;
   logic [ACC_W:0]       sum;
   logic [ACC_W-1:0]     sum_sat;
   logic                 sum_over;
   logic                 sat_now;
   logic [NODE_AW-1:0]   child;

   assign accept  = start && (state_ff == S_IDLE);
   assign node_ok = 32'(req_node_index) < NUM_NODES;
   assign cov_ok  = 32'(req_covariate_index) < NUM_COVARIATES;
   assign act_ok  = 32'(req_leaf_action) < NUM_ACTIONS;
   assign info_rd = node_info_type'(info_rdata);
   assign info_wdata = info_wr;

   // Saturating add of the sign-extended reward onto the stored accumulator.
   assign sum      = {reward_rdata[ACC_W-1], reward_rdata}
                   + {{(ACC_W + 1 - REWARD_W){amount_ff[REWARD_W-1]}}, amount_ff};
   assign sum_over = sum[ACC_W] ^ sum[ACC_W-1];
   assign sum_sat  = sum_over ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];
   assign sat_now  = sat_ff || (add_ff && sum_over);

   // Child chosen by the signed compare of covariate against threshold.
   assign child = ($signed(feat_rdata) <= $signed(thr_ff))
                ? {node_ff[NODE_AW-2:0], 1'b0} + NODE_AW'(1)
                : {node_ff[NODE_AW-2:0], 1'b0} + NODE_AW'(2);

   // The covariate store is always addressed by the split covariate just read.
   assign feat_raddr = FEAT_AW'(info_rd.covariate);

   // Node table read address: root or requested node when idle, child after a compare.
   always_comb begin
      case (state_ff)
         S_IDLE:  node_raddr = (req_opcode == OP_READ_REWARD) ? NODE_AW'(req_node_index)
                                                              : '0;
         S_FEAT:  node_raddr = child;
         default: node_raddr = node_ff;
      endcase
   end

   // Sequencer and write port control.
   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      node_in       = node_ff;
      thr_in        = thr_ff;
      amount_in     = amount_ff;
      add_in        = add_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = 1'b0;
      rsp_action_in = ACTION_NONE;
      rsp_reward_in = '0;
      rsp_status_in = ST_OK;
      info_we       = 1'b0;
      action_we     = 1'b0;
      reward_we     = 1'b0;
      feat_we       = 1'b0;
      node_waddr    = NODE_AW'(req_node_index);
      info_wr       = '0;
      action_wdata  = {1'b0, req_leaf_action};
      reward_wdata  = {{(ACC_W - REWARD_W){req_reward[REWARD_W-1]}}, req_reward};
      feat_waddr    = FEAT_AW'(req_covariate_index);
      feat_wdata    = req_value;

      case (state_ff)
         S_CLEAR: begin
            // Sweep both stores to their reset contents.
            node_waddr   = clear_ff[NODE_AW-1:0];
            feat_waddr   = clear_ff[FEAT_AW-1:0];
            info_we      = 32'(clear_ff) < NUM_NODES;
            action_we    = info_we;
            reward_we    = info_we;
            feat_we      = 32'(clear_ff) < NUM_COVARIATES;
            action_wdata = ACTION_NONE;
            reward_wdata = '0;
            feat_wdata   = '0;
            clear_in     = clear_ff + CLR_W'(1);
            if (clear_ff == CLR_W'(CLEAR_LEN - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_WRITE_SPLIT: begin
                     rsp_valid_in = 1'b1;
                     if (node_ok && cov_ok) begin
                        info_wr.split     = 1'b1;
                        info_wr.covariate = req_covariate_index;
                        info_wr.threshold = req_value;
                        info_we           = 1'b1;
                        reward_we         = 1'b1;
                     end else begin
                        rsp_status_in = ST_BAD_INDEX;
                     end
                  end
                  OP_WRITE_LEAF: begin
                     rsp_valid_in = 1'b1;
                     if (node_ok && act_ok) begin
                        info_we   = 1'b1;
                        action_we = 1'b1;
                        reward_we = 1'b1;
                     end else begin
                        rsp_status_in = ST_BAD_INDEX;
                     end
                  end
                  OP_LOAD_COV: begin
                     rsp_valid_in = 1'b1;
                     if (cov_ok) begin
                        feat_we = 1'b1;
                     end else begin
                        rsp_status_in = ST_BAD_INDEX;
                     end
                  end
                  OP_CLASSIFY, OP_ADD_REWARD: begin
                     // The root read is issued at this edge.
                     state_in  = S_NODE;
                     node_in   = '0;
                     add_in    = (req_opcode == OP_ADD_REWARD);
                     amount_in = req_reward;
                     sat_in    = 1'b0;
                  end
                  OP_READ_REWARD: begin
                     if (node_ok) begin
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_INDEX;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BAD_INDEX;
                  end
               endcase
            end
         end

         S_NODE: begin
            // Node data is here: update its reward and decide whether to go on.
            node_waddr   = node_ff;
            reward_wdata = sum_sat;
            reward_we    = add_ff;
            sat_in       = sat_now;
            thr_in       = info_rd.threshold;
            if (!info_rd.split) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_action_in = action_rdata;
               rsp_status_in = sat_now ? ST_SATURATED : ST_OK;
            end else if (32'(node_ff) >= FIRST_LEAF) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_action_in = action_rdata;
               rsp_status_in = ST_PAST_LAST;
            end else begin
               state_in = S_FEAT;
            end
         end

         S_FEAT: begin
            // Covariate is here: step to the child, whose read goes out now.
            node_in  = child;
            state_in = S_NODE;
         end

         S_READ: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_reward_in = reward_rdata;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk and result payload registers.
   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      thr_ff        <= thr_in;
      amount_ff     <= amount_in;
      add_ff        <= add_in;
      sat_ff        <= sat_in;
      rsp_action_ff <= rsp_action_in;
      rsp_reward_ff <= rsp_reward_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Node table: split information, action and reward accumulator.
   dte_ram #(.WIDTH(NODE_INFO_W), .DEPTH(NUM_NODES)) u_info_ram (
      .clock      (clock),
      .write_en   (info_we),
      .write_addr (node_waddr),
      .write_data (info_wdata),
      .read_addr  (node_raddr),
      .read_data  (info_rdata)
   );

   dte_ram #(.WIDTH(ACTION_W), .DEPTH(NUM_NODES)) u_action_ram (
      .clock      (clock),
      .write_en   (action_we),
      .write_addr (node_waddr),
      .write_data (action_wdata),
      .read_addr  (node_raddr),
      .read_data  (action_rdata)
   );

   dte_ram #(.WIDTH(ACC_W), .DEPTH(NUM_NODES)) u_reward_ram (
      .clock      (clock),
      .write_en   (reward_we),
      .write_addr (node_waddr),
      .write_data (reward_wdata),
      .read_addr  (node_raddr),
      .read_data  (reward_rdata)
   );

   // Covariate values of the current unit.
   dte_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_COVARIATES)) u_feat_ram (
      .clock      (clock),
      .write_en   (feat_we),
      .write_addr (feat_waddr),
      .write_data (feat_wdata),
      .read_addr  (feat_raddr),
      .read_data  (feat_rdata)
   );

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action_out = rsp_action_ff;
   assign rsp_reward_out = rsp_reward_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

FILE: rtl/core/dte_ram.sv
`default_nettype none
module dte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule
`default_nettype wire
